// ===== sv/kst_pkg.sv =====
// kst_pkg: shared types and constants for the keyed slot table
// request and status codes, table geometry and the result struct
// no dependencies
package kst_pkg;

  localparam int unsigned SLOT_COUNT = 128;
  localparam int unsigned SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned IDX_OUT_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD  = 2'd0,
    REQ_DEL  = 2'd1,
    REQ_FIND = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_DELETED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FOUND    = 3'd5
  } status_e;

  typedef struct packed {
    status_e              status;
    logic [IDX_OUT_W-1:0] slot_index;
  } res_t;

endpackage

// ===== sv/kst_ram.sv =====
// kst_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module kst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ===== sv/kst_scan.sv =====
// kst_scan: sequencer and shared key comparator that sweep the slots for one item
// holds the valid bits and drives the key RAM ports; uses kst_pkg
module kst_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kst_pkg::REQ_W-1:0]   req_type_i,
  input  logic [kst_pkg::KEY_W-1:0]   item_key_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output kst_pkg::res_t               res_o,
  output logic [kst_pkg::SLOT_W-1:0]  ram_rd_addr_o,
  input  logic [kst_pkg::KEY_W-1:0]   ram_rd_data_i,
  output logic                        ram_wr_en_o,
  output logic [kst_pkg::SLOT_W-1:0]  ram_wr_addr_o,
  output logic [kst_pkg::KEY_W-1:0]   ram_wr_data_o
);
  import kst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_DONE  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [SLOT_W-1:0]   cmp_idx_q, cmp_idx_d;
  req_e                req_q;
  logic [KEY_W-1:0]    key_q;
  logic                hit_q, hit_d;
  logic [SLOT_W-1:0]   match_idx_q, match_idx_d;
  logic                free_q, free_d;
  logic [SLOT_W-1:0]   free_idx_q, free_idx_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic                accept;
  logic                sweep_end;
  logic                cmp_hit;
  logic                cmp_free;
  logic                res_fire;
  logic                set_valid;
  logic                clr_valid;

  assign accept    = (state_q == S_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign sweep_end = (cnt_q == CNT_W'(SLOT_COUNT));
  assign cmp_hit   = cmp_vld_q && valid_q[cmp_idx_q] && (ram_rd_data_i == key_q);
  assign cmp_free  = cmp_vld_q && !valid_q[cmp_idx_q];
  assign res_valid_o = (state_q == S_DONE);
  assign res_fire  = res_valid_o && res_ready_i;
  assign ram_rd_addr_o = cnt_q[SLOT_W-1:0];
  assign ram_wr_addr_o = free_idx_q;
  assign ram_wr_data_o = key_q;

  always_comb begin
    res_o.status     = ST_NOTFOUND;
    res_o.slot_index = '0;
    set_valid        = 1'b0;
    clr_valid        = 1'b0;
    case (req_q)
      REQ_ADD: begin
        if (hit_q) begin
          res_o.status     = ST_PRESENT;
          res_o.slot_index = IDX_OUT_W'(match_idx_q);
        end else if (free_q) begin
          res_o.status     = ST_ADDED;
          res_o.slot_index = IDX_OUT_W'(free_idx_q);
          set_valid        = 1'b1;
        end else begin
          res_o.status     = ST_FULL;
        end
      end
      REQ_DEL: begin
        if (hit_q) begin
          res_o.status     = ST_DELETED;
          res_o.slot_index = IDX_OUT_W'(match_idx_q);
          clr_valid        = 1'b1;
        end
      end
      REQ_FIND: begin
        if (hit_q) begin
          res_o.status     = ST_FOUND;
          res_o.slot_index = IDX_OUT_W'(match_idx_q);
        end
      end
      default: begin
        res_o.status     = ST_NOTFOUND;
      end
    endcase
  end

  assign ram_wr_en_o = res_fire && set_valid;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    valid_d     = valid_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SWEEP;
          cnt_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      S_SWEEP: begin
        if (cmp_hit && !hit_q) begin
          hit_d       = 1'b1;
          match_idx_d = cmp_idx_q;
        end
        if (cmp_free && !free_q) begin
          free_d      = 1'b1;
          free_idx_d  = cmp_idx_q;
        end
        if (sweep_end) begin
          state_d = S_DONE;
        end else begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = cnt_q[SLOT_W-1:0];
          cnt_d     = cnt_q + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (res_fire) begin
          state_d = S_IDLE;
          if (set_valid) begin
            valid_d[free_idx_q] = 1'b1;
          end
          if (clr_valid) begin
            valid_d[match_idx_q] = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      valid_q   <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    if (accept) begin
      req_q <= req_e'(req_type_i);
      key_q <= item_key_i;
    end
  end

endmodule

// ===== sv/keyed_slot_table_top.sv =====
// keyed_slot_table_top: slot table that adds, deletes and finds 32-bit keys
// instantiates kst_ram and kst_scan; uses kst_pkg
//
// Each item is a request (add, delete or find) on a table of SLOT_COUNT slots,
// and each item gives exactly one result item with a status and a slot index.
// For each item the block sweeps all SLOT_COUNT slots. A single key
// comparator reads the key RAM one slot per cycle. A further sweep step
// covers the registered read data of the last slot. Then the done state
// gives the result and updates the table, and the block returns to idle to
// take the next item. The valid bits are flip-flops cleared by reset, so the
// table is usable right after reset with no clearing pass. A finished result
// sits in an output register, so the next item is taken while that result is
// still stalled. If that result is still stalled when the next sweep ends,
// the new result waits in the done state until the output register frees.
module keyed_slot_table_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [kst_pkg::REQ_W-1:0]       req_type_i,
  input  logic signed [kst_pkg::KEY_W-1:0] item_key_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [kst_pkg::STATUS_W-1:0]    status_o,
  output logic [kst_pkg::IDX_OUT_W-1:0]   slot_index_o
);
  import kst_pkg::*;

  logic                res_valid;
  logic                res_ready;
  res_t                res;
  logic [SLOT_W-1:0]   ram_rd_addr;
  logic [KEY_W-1:0]    ram_rd_data;
  logic                ram_wr_en;
  logic [SLOT_W-1:0]   ram_wr_addr;
  logic [KEY_W-1:0]    ram_wr_data;
  logic                out_valid_q;
  res_t                out_res_q;

  kst_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOT_COUNT)
  ) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  kst_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .item_key_i    (item_key_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_res_q.status;
  assign slot_index_o = out_res_q.slot_index;

endmodule

// ===== sv/kst_checker.sv =====
// kst_checker: port-level assertions for keyed_slot_table_top, bound to it below
// uses kst_pkg
module kst_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [kst_pkg::STATUS_W-1:0]    status_o,
  input logic [kst_pkg::IDX_OUT_W-1:0]   slot_index_o
);
  import kst_pkg::*;

  // an accepted item keeps the block busy for the sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block took a second item right after an accept");

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(slot_index_o)))
    else $error("stalled result item changed");

  // full and not found carry slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL || status_o == ST_NOTFOUND))
      |-> (slot_index_o == '0))
    else $error("nonzero slot with full or not found");

  // no result item appears without a sweep having run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result item without a busy sweep");

endmodule

bind keyed_slot_table_top kst_checker u_kst_checker (.*);
